/* rtl/core/assert_macros.svh */
// Assertion macros shared by the quaternion to rotation matrix block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset
`define QRM_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("qrm: assertion failed");
// Check that a condition in one cycle implies another in the next
`define QRM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qrm: assertion failed");
`else
`define QRM_ASSERT(label, prop)
`define QRM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/core/qrm_pkg.sv */
// Types, constants and helpers of the quaternion to rotation matrix block
`timescale 1ns / 1ps
package qrm_pkg;

    localparam int QW    = 16;  // internal component width, Q2.13
    localparam int CTR_W = 24;
    localparam int N_W   = 33;  // squared norm
    localparam int Y_W   = 31;  // inverse square root, Q1.30
    localparam int C_W   = 34;  // scaled components, Q.30
    localparam int P_W   = 68;  // component products
    localparam int E_W   = 70;  // matrix entry before rounding
    localparam int ENT_W = 16;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_NORM  = 2'd0;
    localparam mode_t MODE_FAST  = 2'd1;
    localparam mode_t MODE_TRANS = 2'd2;
    localparam mode_t MODE_RSVD  = 2'd3;  // unused code, behaves as normalized

    typedef logic signed [QW-1:0]    comp_t;
    typedef logic signed [CTR_W-1:0] ctr_t;

    // Side data that travels with every item
    typedef struct packed {
        mode_t      mode;
        logic       zero;
        logic [4:0] shr;
        comp_t      qw;
        comp_t      qx;
        comp_t      qy;
        comp_t      qz;
        ctr_t       cx;
        ctr_t       cy;
        ctr_t       cz;
    } side_t;

    // Newton iterate and scaled norm
    typedef struct packed {
        logic [Y_W-1:0] y;
        logic [Y_W-1:0] mm;
    } nwt_t;

    // Result beat, last field in the lowest bits
    typedef struct packed {
        ctr_t                        tz;
        ctr_t                        ty;
        ctr_t                        tx;
        logic [8:0][ENT_W-1:0]       m;
    } result_t;

    localparam logic [Y_W-1:0]  SEED_C     = 31'd1825361101;
    localparam logic [Y_W-1:0]  SEED_HI_C  = 31'd1342177280;
    localparam logic [31:0]     DIV7_C     = 32'd3006477107;
    localparam logic [31:0]     THREE_Q30  = 32'd3221225472;
    localparam logic signed [C_W-1:0] ONE_Q30 = {{(C_W-31){1'b0}}, 1'b1, 30'd0};
    localparam logic signed [E_W-1:0] ONE_Q60 = {{(E_W-61){1'b0}}, 1'b1, 60'd0};
    localparam logic signed [E_W-1:0] RND_HALF = {{(E_W-46){1'b0}}, 1'b1, 45'd0};

    // Round half up from Q.60 to Q1.14 and saturate
    function automatic logic [ENT_W-1:0] rnd_sat(input logic signed [E_W-1:0] v);
        logic signed [E_W-1:0] r;
        begin
            r = (v + RND_HALF) >>> 46;
            if (r > 32767)
                r = 32767;
            else if (r < -32768)
                r = -32768;
            return r[ENT_W-1:0];
        end
    endfunction

endpackage

/* rtl/core/quaternion_to_rotation_matrix.sv */
// Throughput: one quaternion per cycle while the skid stage is empty.
// Each Newton step is three multiplier stages.
// A stall on the output freezes the whole pipeline once the skid stage is full.
// Reset clears all valid bits and sets mode to normalized with centre translation.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module quaternion_to_rotation_matrix #(
    parameter int NEWTON_STEPS    = 3,
    parameter int COMPONENT_WIDTH = 16,
    parameter int IN_TW = ((4 * COMPONENT_WIDTH + 72 + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // quat_w, quat_x, quat_y, quat_z, center_x, center_y, center_z
    input  logic [IN_TW-1:0] s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // m_r0c0 .. m_r2c2 (row-major), trans_x, trans_y, trans_z
    output logic [$bits(qrm_pkg::result_t)-1:0] m_tdata,
    input  logic             mode_wr_en,
    input  logic [1:0]       mode_wr_data
);
    import qrm_pkg::*;

    localparam int CW = COMPONENT_WIDTH;

    mode_t   mode_reg;
    logic    en;
    logic    nv [NEWTON_STEPS+1];
    side_t   ns [NEWTON_STEPS+1];
    nwt_t    nn [NEWTON_STEPS+1];
    logic    mat_valid;
    result_t mat_data, out_data;

    // Hold the mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_NORM;
        else if (mode_wr_en)
            mode_reg <= mode_wr_data;
    end

    assign s_tready = en;

    qrm_norm #(
        .COMPONENT_WIDTH(COMPONENT_WIDTH)
    ) u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .quat_w   (s_tdata[CW-1:0]),
        .quat_x   (s_tdata[2*CW-1:CW]),
        .quat_y   (s_tdata[3*CW-1:2*CW]),
        .quat_z   (s_tdata[4*CW-1:3*CW]),
        .center_x (s_tdata[4*CW+23:4*CW]),
        .center_y (s_tdata[4*CW+47:4*CW+24]),
        .center_z (s_tdata[4*CW+71:4*CW+48]),
        .mode     (mode_reg),
        .out_valid(nv[0]),
        .out_side (ns[0]),
        .out_nwt  (nn[0])
    );

    // Chain the Newton steps
    for (genvar g = 0; g < NEWTON_STEPS; g++)
    begin : g_newton
        qrm_newton u_newton (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (nv[g]),
            .in_side  (ns[g]),
            .in_nwt   (nn[g]),
            .out_valid(nv[g+1]),
            .out_side (ns[g+1]),
            .out_nwt  (nn[g+1])
        );
    end

    qrm_matrix u_matrix (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (nv[NEWTON_STEPS]),
        .in_side  (ns[NEWTON_STEPS]),
        .in_nwt   (nn[NEWTON_STEPS]),
        .out_valid(mat_valid),
        .out_data (mat_data)
    );

    qrm_skid u_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (mat_valid),
        .in_data  (mat_data),
        .in_ready (en),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (out_data)
    );

    assign m_tdata = out_data;

    // A frozen pipeline always has a beat on the output
    `QRM_ASSERT(a_stall_has_beat, !s_tready |-> m_tvalid)
    // A taken output drains the skid stage in the next cycle
    `QRM_ASSERT_NEXT(a_skid_drains, !s_tready && m_tready, s_tready)
    // A beat arriving on a stalled output fills the skid stage
    `QRM_ASSERT_NEXT(a_skid_fills, m_tvalid && !m_tready && mat_valid && s_tready, !s_tready)

endmodule

/* rtl/core/qrm_norm.sv */
// Input stage, squared norm, range reduction and seed of the inverse square root
`timescale 1ns / 1ps
module qrm_norm #(
    parameter int COMPONENT_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [COMPONENT_WIDTH-1:0] quat_w,
    input  logic signed [COMPONENT_WIDTH-1:0] quat_x,
    input  logic signed [COMPONENT_WIDTH-1:0] quat_y,
    input  logic signed [COMPONENT_WIDTH-1:0] quat_z,
    input  qrm_pkg::ctr_t                     center_x,
    input  qrm_pkg::ctr_t                     center_y,
    input  qrm_pkg::ctr_t                     center_z,
    input  qrm_pkg::mode_t                    mode,
    output logic                              out_valid,
    output qrm_pkg::side_t                    out_side,
    output qrm_pkg::nwt_t                     out_nwt
);
    import qrm_pkg::*;

    localparam int SH_R = (COMPONENT_WIDTH > 16) ? COMPONENT_WIDTH - 16 : 0;
    localparam int SH_L = (COMPONENT_WIDTH < 16) ? 16 - COMPONENT_WIDTH : 0;
    localparam int XW   = COMPONENT_WIDTH + 16;

    // Bring a component to Q2.13, flooring when it is wider
    function automatic comp_t to_q13(input logic signed [COMPONENT_WIDTH-1:0] v);
        logic signed [XW-1:0] e;
        begin
            e = XW'(v);
            e = (e <<< SH_L) >>> SH_R;
            return e[QW-1:0];
        end
    endfunction

    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    side_t       side1_reg, side2_reg, side3_reg, side4_reg, side5_reg;
    side_t       side1_next, side3_next;
    logic [N_W-1:0] n2_reg, n2_next;
    logic [Y_W-1:0] m3_reg, m3_next, m4_reg, m5_reg;
    logic [29:0]    qd4_reg;
    logic           ge4_reg;
    logic [Y_W-1:0] yhi4_reg, y5_next, y5_reg;
    logic [61:0]    div_prod;
    logic [5:0]     len, alen;
    logic [N_W-1:0] nsh;
    logic signed [31:0] sqw, sqx, sqy, sqz;
    logic [33:0]    rem;
    logic [Y_W-1:0] qd;

    // Capture the item in internal format
    always_comb
    begin
        side1_next      = '0;
        side1_next.mode = mode;
        side1_next.qw   = to_q13(quat_w);
        side1_next.qx   = to_q13(quat_x);
        side1_next.qy   = to_q13(quat_y);
        side1_next.qz   = to_q13(quat_z);
        side1_next.cx   = center_x;
        side1_next.cy   = center_y;
        side1_next.cz   = center_z;
    end

    // Sum the squares
    always_comb
    begin
        sqw     = side1_reg.qw * side1_reg.qw;
        sqx     = side1_reg.qx * side1_reg.qx;
        sqy     = side1_reg.qy * side1_reg.qy;
        sqz     = side1_reg.qz * side1_reg.qz;
        n2_next = N_W'(sqw[30:0]) + N_W'(sqx[30:0]) + N_W'(sqy[30:0]) + N_W'(sqz[30:0]);
    end

    // Scale the norm by an even power of two into [0.5, 2)
    always_comb
    begin
        len = '0;
        for (int i = 0; i < N_W; i++)
        begin
            if (n2_reg[i])
                len = 6'(i + 1);
        end
        alen            = (6'd33 - len) & 6'b111110;
        nsh             = n2_reg << alen;
        m3_next         = nsh[N_W-1:2];
        side3_next      = side2_reg;
        side3_next.zero = (n2_reg == '0);
        side3_next.shr  = 5'(5'd16 - alen[5:1]);
    end

    // Estimate 7M/10 by reciprocal
    assign div_prod = 62'(m3_reg[29:0]) * 62'(DIV7_C);

    // Correct the quotient and pick the seed
    always_comb
    begin
        rem     = 34'(m4_reg) * 34'd7 - 34'(qd4_reg) * 34'd10;
        qd      = 31'(qd4_reg) + 31'(rem >= 34'd10);
        y5_next = ge4_reg ? yhi4_reg : SEED_C - qd;
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg <= side1_next;
            side2_reg <= side1_reg;
            n2_reg    <= n2_next;
            side3_reg <= side3_next;
            m3_reg    <= m3_next;
            side4_reg <= side3_reg;
            m4_reg    <= m3_reg;
            ge4_reg   <= m3_reg[Y_W-1];
            qd4_reg   <= div_prod[61:32];
            yhi4_reg  <= SEED_HI_C - {2'b00, m3_reg[Y_W-1:2]};
            side5_reg <= side4_reg;
            m5_reg    <= m4_reg;
            y5_reg    <= y5_next;
        end
    end

    assign out_valid  = v5_reg;
    assign out_side   = side5_reg;
    assign out_nwt.y  = y5_reg;
    assign out_nwt.mm = m5_reg;

endmodule

/* rtl/core/qrm_newton.sv */
// One Newton step of the inverse square root over three register stages
`timescale 1ns / 1ps
module qrm_newton (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  qrm_pkg::side_t in_side,
    input  qrm_pkg::nwt_t  in_nwt,
    output logic           out_valid,
    output qrm_pkg::side_t out_side,
    output qrm_pkg::nwt_t  out_nwt
);
    import qrm_pkg::*;

    logic        va_reg, vb_reg, vc_reg;
    side_t       sa_reg, sb_reg, sc_reg;
    nwt_t        na_reg, nb_reg, nc_reg;
    logic [31:0] sq_reg;
    logic [32:0] u_reg;
    logic [61:0] yy;
    logic [62:0] mu, yd;
    logic [31:0] d;
    logic [Y_W-1:0] y_next;

    // Square the iterate, scale by the norm, then refine
    always_comb
    begin
        yy     = 62'(in_nwt.y) * 62'(in_nwt.y);
        mu     = 63'(na_reg.mm) * 63'(sq_reg);
        d      = (u_reg >= 33'(THREE_Q30)) ? 32'd0 : 32'(33'(THREE_Q30) - u_reg);
        yd     = 63'(nb_reg.y) * 63'(d);
        y_next = yd[61:31];
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_reg    <= in_side;
            na_reg    <= in_nwt;
            sq_reg    <= yy[61:30];
            sb_reg    <= sa_reg;
            nb_reg    <= na_reg;
            u_reg     <= mu[62:30];
            sc_reg    <= sb_reg;
            nc_reg.mm <= nb_reg.mm;
            nc_reg.y  <= y_next;
        end
    end

    assign out_valid = vc_reg;
    assign out_side  = sc_reg;
    assign out_nwt   = nc_reg;

endmodule

/* rtl/core/qrm_matrix.sv */
// Component scaling, products and rounded matrix entries
`timescale 1ns / 1ps
module qrm_matrix (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  qrm_pkg::side_t   in_side,
    input  qrm_pkg::nwt_t    in_nwt,
    output logic             out_valid,
    output qrm_pkg::result_t out_data
);
    import qrm_pkg::*;

    logic  va_reg, vb_reg, vc_reg, vd_reg;
    side_t sa_reg, sb_reg, sc_reg;
    logic signed [47:0]    p_reg [4];
    logic signed [47:0]    p_next [4];
    logic signed [C_W-1:0] c_reg [4];
    logic signed [C_W-1:0] c_next [4];
    logic signed [P_W-1:0] pr_reg [9];
    logic signed [P_W-1:0] pr_next [9];
    logic signed [E_W-1:0] ex [9];
    logic [ENT_W-1:0]      ent [9];
    comp_t                 qa [4];
    result_t               res_next, res_reg;

    // Scale components by the inverse square root
    always_comb
    begin
        qa[0] = in_side.qw;
        qa[1] = in_side.qx;
        qa[2] = in_side.qy;
        qa[3] = in_side.qz;
        for (int i = 0; i < 4; i++)
            p_next[i] = qa[i] * $signed({1'b0, in_nwt.y});
    end

    // Shift back, or take the raw or identity quaternion
    always_comb
    begin
        for (int i = 0; i < 4; i++)
            c_next[i] = C_W'(p_reg[i] >>> sa_reg.shr);
        if (sa_reg.zero)
        begin
            c_next[0] = ONE_Q30;
            c_next[1] = '0;
            c_next[2] = '0;
            c_next[3] = '0;
        end
        else if (sa_reg.mode == MODE_FAST)
        begin
            c_next[0] = C_W'(sa_reg.qw) <<< 17;
            c_next[1] = C_W'(sa_reg.qx) <<< 17;
            c_next[2] = C_W'(sa_reg.qy) <<< 17;
            c_next[3] = C_W'(sa_reg.qz) <<< 17;
        end
    end

    // Form the component products: w=0 x=1 y=2 z=3
    always_comb
    begin
        pr_next[0] = c_reg[1] * c_reg[1];
        pr_next[1] = c_reg[2] * c_reg[2];
        pr_next[2] = c_reg[3] * c_reg[3];
        pr_next[3] = c_reg[1] * c_reg[2];
        pr_next[4] = c_reg[3] * c_reg[0];
        pr_next[5] = c_reg[1] * c_reg[3];
        pr_next[6] = c_reg[2] * c_reg[0];
        pr_next[7] = c_reg[3] * c_reg[2];
        pr_next[8] = c_reg[1] * c_reg[0];
    end

    // Build, round and place the entries
    always_comb
    begin
        for (int i = 0; i < 9; i++)
            ex[i] = E_W'(pr_reg[i]);
        ent[0] = rnd_sat(ONE_Q60 - ((ex[1] + ex[2]) <<< 1));
        ent[1] = rnd_sat((ex[3] + ex[4]) <<< 1);
        ent[2] = rnd_sat((ex[5] - ex[6]) <<< 1);
        ent[3] = rnd_sat((ex[3] - ex[4]) <<< 1);
        ent[4] = rnd_sat(ONE_Q60 - ((ex[0] + ex[2]) <<< 1));
        ent[5] = rnd_sat((ex[7] + ex[8]) <<< 1);
        ent[6] = rnd_sat((ex[5] + ex[6]) <<< 1);
        ent[7] = rnd_sat((ex[7] - ex[8]) <<< 1);
        ent[8] = rnd_sat(ONE_Q60 - ((ex[0] + ex[1]) <<< 1));
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (sc_reg.mode == MODE_TRANS)
                    res_next.m[r*3+k] = ent[k*3+r];
                else
                    res_next.m[r*3+k] = ent[r*3+k];
            end
        end
        if (sc_reg.mode == MODE_FAST || sc_reg.mode == MODE_TRANS)
        begin
            res_next.tx = '0;
            res_next.ty = '0;
            res_next.tz = '0;
        end
        else
        begin
            res_next.tx = sc_reg.cx;
            res_next.ty = sc_reg.cy;
            res_next.tz = sc_reg.cz;
        end
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_reg <= in_side;
            p_reg  <= p_next;
            sb_reg <= sa_reg;
            c_reg  <= c_next;
            sc_reg <= sb_reg;
            pr_reg <= pr_next;
            res_reg <= res_next;
        end
    end

    assign out_valid = vd_reg;
    assign out_data  = res_reg;

endmodule

/* rtl/core/qrm_skid.sv */
// Output register with a skid stage that holds one beat during a stall
`timescale 1ns / 1ps
module qrm_skid (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  qrm_pkg::result_t in_data,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output qrm_pkg::result_t out_data
);
    import qrm_pkg::*;

    logic    out_valid_reg, skid_valid_reg;
    result_t out_data_reg, skid_data_reg;

    // Track occupancy of both registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!skid_valid_reg)
        begin
            if (out_valid_reg && !out_ready)
                skid_valid_reg <= in_valid;
            else
                out_valid_reg <= in_valid;
        end
        else if (out_ready)
        begin
            skid_valid_reg <= 1'b0;
        end
    end

    // Move the beat into the output or park it in the skid stage
    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
        begin
            if (out_valid_reg && !out_ready)
                skid_data_reg <= in_data;
            else
                out_data_reg <= in_data;
        end
        else if (out_ready)
        begin
            out_data_reg <= skid_data_reg;
        end
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* verif/quaternion_to_rotation_matrix_tb.sv */
// Self-checking testbench for the quaternion to rotation matrix block
`timescale 1ns / 1ps
module quaternion_to_rotation_matrix_tb;
    import qrm_pkg::*;

    localparam int TDATA_W    = 136;
    localparam int STALL_MAX  = 3000;
    localparam int LONG_HOLD  = 150;
    localparam int SETTLE     = 30;

    typedef struct {
        mode_t                  mode;
        logic signed [15:0]     q [4];
        logic signed [23:0]     c [3];
        bit                     ident;  // expectation typed in: identity matrix
    } stim_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    // quat_w, quat_x, quat_y, quat_z, center_x, center_y, center_z
    logic [TDATA_W-1:0]             s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    // m_r0c0 .. m_r2c2 (row-major), trans_x, trans_y, trans_z
    logic [$bits(result_t)-1:0]     m_tdata;
    logic                           mode_wr_en;
    logic [1:0]                     mode_wr_data;

    result_t    pending_matrices [$];
    stim_row_t  directed_rows [$];
    mode_t      cur_mode;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         errors;
    int         beats_in;
    int         beats_out;
    int         idle_cycles;
    int         zero_quats;
    bit         long_hold_done;

    quaternion_to_rotation_matrix dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .mode_wr_en   (mode_wr_en),
        .mode_wr_data (mode_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #4 clk = ~clk;
    end

    // Round half up from sh fraction bits to Q1.14 and saturate
    function automatic logic [15:0] round_q14(input longint v, input int sh);
        longint r;
        begin
            r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
            if (r > 32767)
                r = 32767;
            else if (r < -32768)
                r = -32768;
            return r[15:0];
        end
    endfunction

    // Work out the matrix and translation for one quaternion and centre
    function automatic result_t rotation_of(input mode_t md, input logic signed [15:0] qv [4],
                                            input logic signed [23:0] cv [3]);
        result_t            res;
        longint             q [4];
        longint             cs [4];
        longint             one;
        longint unsigned    n, mm, y, sq, u, d;
        int                 len, t, a, f, sh;
        logic [15:0]        tmp;
        begin
            n = 0;
            for (int i = 0; i < 4; i++)
            begin
                q[i] = qv[i];
                n += longint'(q[i] * q[i]);
            end
            f = 13;
            cs = q;
            if (n != 0 && md != MODE_FAST)
            begin
                len = 0;
                while (len < 64 && (n >> len) != 0)
                    len++;
                t = 33 - len;
                a = t - (t & 1);
                mm = (n << a) >> 2;
                if (mm >= (64'd1 << 30))
                    y = (64'd5 << 28) - (mm >> 2);
                else
                    y = 64'd1825361101 - (mm * 7) / 10;
                for (int k = 0; k < 3; k++)
                begin
                    sq = (y * y) >> 30;
                    u  = (mm * sq) >> 30;
                    d  = (u >= (64'd3 << 30)) ? 64'd0 : (64'd3 << 30) - u;
                    y  = (y * d) >> 31;
                end
                for (int i = 0; i < 4; i++)
                    cs[i] = (q[i] * $signed(y)) >>> (16 - a / 2);
                f = 30;
            end
            if (n == 0)
            begin
                for (int i = 0; i < 9; i++)
                    res.m[i] = (i % 4 == 0) ? 16'd16384 : 16'd0;
            end
            else
            begin
                // cs holds w, x, y, z
                one = 64'sd1 <<< (2 * f);
                sh = 2 * f - 14;
                res.m[0] = round_q14(one - 2 * (cs[2] * cs[2] + cs[3] * cs[3]), sh);
                res.m[1] = round_q14(2 * (cs[1] * cs[2] + cs[3] * cs[0]), sh);
                res.m[2] = round_q14(2 * (cs[1] * cs[3] - cs[2] * cs[0]), sh);
                res.m[3] = round_q14(2 * (cs[1] * cs[2] - cs[3] * cs[0]), sh);
                res.m[4] = round_q14(one - 2 * (cs[1] * cs[1] + cs[3] * cs[3]), sh);
                res.m[5] = round_q14(2 * (cs[3] * cs[2] + cs[1] * cs[0]), sh);
                res.m[6] = round_q14(2 * (cs[1] * cs[3] + cs[2] * cs[0]), sh);
                res.m[7] = round_q14(2 * (cs[3] * cs[2] - cs[1] * cs[0]), sh);
                res.m[8] = round_q14(one - 2 * (cs[1] * cs[1] + cs[2] * cs[2]), sh);
            end
            if (md == MODE_TRANS)
            begin
                for (int i = 0; i < 3; i++)
                    for (int j = i + 1; j < 3; j++)
                    begin
                        tmp = res.m[i*3+j];
                        res.m[i*3+j] = res.m[j*3+i];
                        res.m[j*3+i] = tmp;
                    end
            end
            // centre passes through in normalized mode and the unused code
            if (md == MODE_NORM || md == MODE_RSVD)
            begin
                res.tx = cv[0];
                res.ty = cv[1];
                res.tz = cv[2];
            end
            else
            begin
                res.tx = '0;
                res.ty = '0;
                res.tz = '0;
            end
            return res;
        end
    endfunction

    // Offer one beat, with random idle cycles ahead, and log its expectation
    task automatic send_quat(input stim_row_t row);
        result_t exp_res;
        begin
            while ($urandom_range(99, 0) < send_idle_pct)
            begin
                s_tvalid = 1'b0;
                @(negedge clk);
            end
            s_tvalid = 1'b1;
            s_tdata = {row.c[2], row.c[1], row.c[0], row.q[3], row.q[2], row.q[1], row.q[0]};
            if (row.ident)
            begin
                for (int i = 0; i < 9; i++)
                    exp_res.m[i] = (i % 4 == 0) ? 16'd16384 : 16'd0;
                exp_res.tx = (row.mode == MODE_NORM || row.mode == MODE_RSVD) ? row.c[0] : '0;
                exp_res.ty = (row.mode == MODE_NORM || row.mode == MODE_RSVD) ? row.c[1] : '0;
                exp_res.tz = (row.mode == MODE_NORM || row.mode == MODE_RSVD) ? row.c[2] : '0;
            end
            else
                exp_res = rotation_of(cur_mode, row.q, row.c);
            do
                @(posedge clk);
            while (!s_tready);
            pending_matrices.push_back(exp_res);
            beats_in++;
            if (row.q[0] == 0 && row.q[1] == 0 && row.q[2] == 0 && row.q[3] == 0)
                zero_quats++;
            @(negedge clk);
        end
    endtask

    // Drain, then write the mode register while the block is idle
    task automatic write_mode(input mode_t md);
        begin
            s_tvalid = 1'b0;
            wait (pending_matrices.size() == 0);
            repeat (SETTLE) @(negedge clk);
            mode_wr_en = 1'b1;
            mode_wr_data = md;
            @(negedge clk);
            mode_wr_en = 1'b0;
            cur_mode = md;
        end
    endtask

    // Receiver: random back-pressure plus one long hold-off
    initial
    begin
        int hold;
        m_tready = 1'b0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && beats_out == 300)
            begin
                long_hold_done = 1'b1;
                hold = LONG_HOLD;
            end
            if (hold > 0)
            begin
                hold--;
                m_tready = 1'b0;
            end
            else
                m_tready = ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // Compare each output beat against the oldest expectation
    always @(posedge clk)
    begin
        result_t act, exp_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            act = m_tdata;
            beats_out++;
            if (pending_matrices.size() == 0)
            begin
                $display("%0t: unexpected beat %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                exp_res = pending_matrices.pop_front();
                for (int i = 0; i < 9; i++)
                    if (act.m[i] !== exp_res.m[i])
                    begin
                        $display("%0t: entry %0d expected %h actual %h", $time, i,
                                 exp_res.m[i], act.m[i]);
                        errors++;
                    end
                if (act.tx !== exp_res.tx || act.ty !== exp_res.ty || act.tz !== exp_res.tz)
                begin
                    $display("%0t: translation expected %h %h %h actual %h %h %h", $time,
                             exp_res.tx, exp_res.ty, exp_res.tz, act.tx, act.ty, act.tz);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run if no beat moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Add one directed row
    task automatic add_row(input mode_t md, input int w, input int x, input int y, input int z,
                           input int c0, input bit ident);
        stim_row_t row;
        begin
            row.mode = md;
            row.q[0] = 16'(w);
            row.q[1] = 16'(x);
            row.q[2] = 16'(y);
            row.q[3] = 16'(z);
            row.c[0] = 24'(c0);
            row.c[1] = 24'(-c0);
            row.c[2] = 24'(c0) ^ 24'h5a5a5a;
            row.ident = ident;
            directed_rows.push_back(row);
        end
    endtask

    // Random quaternion: full range, small magnitudes, zero or a lone extreme
    function automatic stim_row_t random_row();
        stim_row_t row;
        int kind, sh;
        begin
            row.mode = cur_mode;
            row.ident = 1'b0;
            kind = $urandom_range(99, 0);
            sh = $urandom_range(15, 0);
            for (int i = 0; i < 4; i++)
            begin
                if (kind < 55)
                    row.q[i] = 16'($urandom);
                else if (kind < 85)
                    row.q[i] = $signed(16'($urandom)) >>> sh;
                else if (kind < 92)
                    row.q[i] = '0;
                else
                    row.q[i] = (i == sh % 4) ? ((sh & 4) ? 16'sh8000 : 16'sh7fff) : 16'sd0;
            end
            for (int i = 0; i < 3; i++)
                row.c[i] = 24'($urandom);
            return row;
        end
    endfunction

    initial
    begin
        errors = 0;
        beats_in = 0;
        beats_out = 0;
        idle_cycles = 0;
        zero_quats = 0;
        long_hold_done = 1'b0;
        cur_mode = MODE_NORM;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        mode_wr_en = 1'b0;
        mode_wr_data = MODE_NORM;
        send_idle_pct = 26;
        recv_idle_pct = 72;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: zero quaternion, unit, extremes and saturation in each mode
        add_row(MODE_NORM, 0, 0, 0, 0, 24'h7fffff, 1'b1);
        add_row(MODE_NORM, 8192, 0, 0, 0, 24'h800000, 1'b0);
        add_row(MODE_NORM, -32768, -32768, -32768, -32768, 1, 1'b0);
        add_row(MODE_NORM, 32767, 32767, 32767, 32767, -1, 1'b0);
        add_row(MODE_NORM, 1, 0, 0, 0, 0, 1'b0);
        add_row(MODE_NORM, 0, 0, 0, -1, 12345, 1'b0);
        add_row(MODE_NORM, 5793, 5793, 0, 0, 0, 1'b0);
        add_row(MODE_FAST, 0, 0, 0, 0, 24'h7fffff, 1'b1);
        add_row(MODE_FAST, 8192, 0, 0, 0, 0, 1'b1);
        add_row(MODE_FAST, 32767, 32767, -32768, 32767, 7, 1'b0);
        add_row(MODE_FAST, 0, -32768, 0, 0, 7, 1'b0);
        add_row(MODE_FAST, 1000, -2000, 3000, -4000, 7, 1'b0);
        add_row(MODE_TRANS, 0, 0, 0, 0, 24'h800000, 1'b1);
        add_row(MODE_TRANS, 4096, 4096, 4096, 4096, 5, 1'b0);
        add_row(MODE_TRANS, 100, -3000, 12000, 25000, 5, 1'b0);
        add_row(MODE_TRANS, -32768, 32767, 1, -1, 5, 1'b0);
        add_row(MODE_RSVD, 0, 0, 0, 0, 24'h123456, 1'b1);
        add_row(MODE_RSVD, 3000, 20000, -7000, 1, 24'h654321, 1'b0);
        add_row(MODE_RSVD, 32767, -32768, 32767, -32768, 24'h800000, 1'b0);
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].mode != cur_mode || i == 0)
                write_mode(directed_rows[i].mode);
            send_quat(directed_rows[i]);
        end

        // Random: three idling profiles, each across all four mode codes
        for (int prof = 0; prof < 3; prof++)
        begin
            send_idle_pct = (prof == 0) ? 26 : (prof == 1) ? 72 : 0;
            recv_idle_pct = (prof == 0) ? 72 : (prof == 1) ? 26 : 0;
            for (int md = 0; md < 4; md++)
            begin
                write_mode(mode_t'(md));
                repeat (107)
                    send_quat(random_row());
            end
        end

        // Drain and let the pipeline settle
        s_tvalid = 1'b0;
        wait (pending_matrices.size() == 0);
        repeat (SETTLE) @(negedge clk);
        $display("Covered %0d quaternions (%0d zero) over all mode codes and three idling",
                 beats_in, zero_quats);
        $display("profiles, with a long output hold-off; %0d mismatches.", errors);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
